### sv/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

    localparam int HUE_BITS     = 16;
    localparam int CHANNEL_BITS = 8;
    localparam int SECTOR_BITS  = 3;
    localparam int PROD_BITS    = 2 * CHANNEL_BITS;
    localparam int DEN_BITS     = HUE_BITS + CHANNEL_BITS;
    localparam int NUM_BITS     = DEN_BITS + CHANNEL_BITS;

    localparam logic [CHANNEL_BITS-1:0] CH_MAX   = '1;
    // full-scale blend denominator: CH_MAX * 2^HUE_BITS
    localparam logic [DEN_BITS-1:0]     DEN_FULL = DEN_BITS'(CH_MAX) << HUE_BITS;

    // hue sectors, sixths of a turn
    localparam logic [SECTOR_BITS-1:0] SEC_RED_YEL = 3'd0;
    localparam logic [SECTOR_BITS-1:0] SEC_YEL_GRN = 3'd1;
    localparam logic [SECTOR_BITS-1:0] SEC_GRN_CYN = 3'd2;
    localparam logic [SECTOR_BITS-1:0] SEC_CYN_BLU = 3'd3;
    localparam logic [SECTOR_BITS-1:0] SEC_BLU_MAG = 3'd4;

    typedef struct packed {
        logic [HUE_BITS-1:0]     hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } hsv_pix_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } rgb_pix_t;

    typedef struct packed {
        logic [SECTOR_BITS-1:0]  sector;
        logic [HUE_BITS-1:0]     frac;
        logic [CHANNEL_BITS-1:0] sat;
        logic [CHANNEL_BITS-1:0] val;
        logic [PROD_BITS-1:0]    p_num;
    } sec_stage_t;

    typedef struct packed {
        logic [SECTOR_BITS-1:0]  sector;
        logic [CHANNEL_BITS-1:0] val;
        logic [CHANNEL_BITS-1:0] p;
        logic [PROD_BITS-1:0]    q_num;
        logic [PROD_BITS-1:0]    t_num;
    } blend_stage_t;

    // floor(n / CH_MAX) for n <= CH_MAX * CH_MAX: reciprocal estimate that never
    // overshoots, then one compare-and-bump
    function automatic logic [CHANNEL_BITS-1:0] div_maxc(input logic [PROD_BITS-1:0] n);
        logic [PROD_BITS:0]    sum;
        logic [CHANNEL_BITS:0] est;
        logic [PROD_BITS:0]    back;
        logic [PROD_BITS:0]    rem;
        sum  = {1'b0, n} + (PROD_BITS + 1)'(n >> CHANNEL_BITS);
        est  = sum[PROD_BITS:CHANNEL_BITS];
        back = ((PROD_BITS + 1)'(est) << CHANNEL_BITS) - (PROD_BITS + 1)'(est);
        rem  = {1'b0, n} - back;
        return CHANNEL_BITS'(est + (CHANNEL_BITS + 1)'(rem >= (PROD_BITS + 1)'(CH_MAX)));
    endfunction

endpackage

### sv/hsv_to_rgb_converter.sv
// channel | valid     | stall     | beat
// --------+-----------+-----------+---------------------------------------
// input   | hsv_valid | hsv_stall | hsv: hue, saturation, brightness
// output  | rgb_valid | rgb_stall | rgb: red, green, blue
//
// One beat per clock while the output is not stalled; the stages are sector and p product,
// weights, value scale, and divide-and-route.
// Reset clears only the stage valid bits; no clearing pass.
// A stalled output beat freezes every stage; hsv_stall is high exactly then.
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     hsv_valid,
    output logic     hsv_stall,
    input  hsv_pix_t hsv,
    output logic     rgb_valid,
    input  logic     rgb_stall,
    output rgb_pix_t rgb
);

    logic         en;
    logic         sec_valid;
    sec_stage_t   sec_st;
    logic         blend_valid;
    blend_stage_t blend_st;

    assign en        = !(rgb_valid && rgb_stall);
    assign hsv_stall = !en;

    hsv2rgb_sector u_sector
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (hsv_valid),
        .in_pix    (hsv),
        .out_valid (sec_valid),
        .out_st    (sec_st)
    );

    hsv2rgb_blend u_blend
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sec_valid),
        .in_st     (sec_st),
        .out_valid (blend_valid),
        .out_st    (blend_st)
    );

    hsv2rgb_route u_route
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (blend_valid),
        .in_st     (blend_st),
        .out_valid (rgb_valid),
        .out_pix   (rgb)
    );

endmodule

### sv/hsv2rgb_sector.sv
module hsv2rgb_sector
    import hsv2rgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  hsv_pix_t   in_pix,
    output logic       out_valid,
    output sec_stage_t out_st
);

    logic                       valid_reg;
    sec_stage_t                 st_reg;
    sec_stage_t                 st_next;
    logic [HUE_BITS+2:0]        hue_x6;
    logic [CHANNEL_BITS-1:0]    sat_inv;

    always_comb
    begin
        // hue * 6 as two shifted adds; top bits give the sector
        hue_x6  = ((HUE_BITS + 3)'(in_pix.hue) << 2) + ((HUE_BITS + 3)'(in_pix.hue) << 1);
        sat_inv = CH_MAX - in_pix.saturation;
        st_next.sector = hue_x6[HUE_BITS+2:HUE_BITS];
        st_next.frac   = hue_x6[HUE_BITS-1:0];
        st_next.sat    = in_pix.saturation;
        st_next.val    = in_pix.brightness;
        st_next.p_num  = PROD_BITS'(in_pix.brightness) * PROD_BITS'(sat_inv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            st_reg <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;

endmodule

### sv/hsv2rgb_blend.sv
module hsv2rgb_blend
    import hsv2rgb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  sec_stage_t   in_st,
    output logic         out_valid,
    output blend_stage_t out_st
);

    // stage A: fractional weights and p
    logic                     a_valid_reg;
    logic [SECTOR_BITS-1:0]   a_sector_reg;
    logic [CHANNEL_BITS-1:0]  a_val_reg;
    logic [CHANNEL_BITS-1:0]  a_p_reg;
    logic [DEN_BITS-1:0]      a_qden_reg;
    logic [DEN_BITS-1:0]      a_tden_reg;
    logic [DEN_BITS-1:0]      frac_sat;
    logic [CHANNEL_BITS-1:0]  a_p_next;
    logic [DEN_BITS-1:0]      a_qden_next;
    logic [DEN_BITS-1:0]      a_tden_next;

    // stage B: scaled by value
    logic                     b_valid_reg;
    blend_stage_t             b_st_reg;
    blend_stage_t             b_st_next;
    logic [NUM_BITS-1:0]      q_prod;
    logic [NUM_BITS-1:0]      t_prod;

    always_comb
    begin
        frac_sat    = DEN_BITS'(in_st.frac) * DEN_BITS'(in_st.sat);
        a_p_next    = div_maxc(in_st.p_num);
        a_qden_next = DEN_FULL - frac_sat;
        // (1 - f) * s = s * 2^HUE_BITS - f * s
        a_tden_next = DEN_FULL - (DEN_BITS'(in_st.sat) << HUE_BITS) + frac_sat;
    end

    always_comb
    begin
        q_prod = NUM_BITS'(a_val_reg) * NUM_BITS'(a_qden_reg);
        t_prod = NUM_BITS'(a_val_reg) * NUM_BITS'(a_tden_reg);
        b_st_next.sector = a_sector_reg;
        b_st_next.val    = a_val_reg;
        b_st_next.p      = a_p_reg;
        b_st_next.q_num  = q_prod[NUM_BITS-1:HUE_BITS];
        b_st_next.t_num  = t_prod[NUM_BITS-1:HUE_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            a_sector_reg <= in_st.sector;
            a_val_reg    <= in_st.val;
            a_p_reg      <= a_p_next;
            a_qden_reg   <= a_qden_next;
            a_tden_reg   <= a_tden_next;
        end
        if (en && a_valid_reg)
        begin
            b_st_reg <= b_st_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_st    = b_st_reg;

endmodule

### sv/hsv2rgb_route.sv
module hsv2rgb_route
    import hsv2rgb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  blend_stage_t in_st,
    output logic         out_valid,
    output rgb_pix_t     out_pix
);

    logic                    valid_reg;
    rgb_pix_t                pix_reg;
    rgb_pix_t                pix_next;
    logic [CHANNEL_BITS-1:0] q;
    logic [CHANNEL_BITS-1:0] t;

    always_comb
    begin
        q = div_maxc(in_st.q_num);
        t = div_maxc(in_st.t_num);
        case (in_st.sector)
            SEC_RED_YEL: pix_next = '{red: in_st.val, green: t,         blue: in_st.p};
            SEC_YEL_GRN: pix_next = '{red: q,         green: in_st.val, blue: in_st.p};
            SEC_GRN_CYN: pix_next = '{red: in_st.p,   green: in_st.val, blue: t};
            SEC_CYN_BLU: pix_next = '{red: in_st.p,   green: q,         blue: in_st.val};
            SEC_BLU_MAG: pix_next = '{red: t,         green: in_st.p,   blue: in_st.val};
            default:     pix_next = '{red: in_st.val, green: in_st.p,   blue: q};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

### dv/hsv_to_rgb_checker.sv
`timescale 1ns / 100ps

module hsv_to_rgb_checker
    import hsv2rgb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     hsv_valid,
    input  logic     hsv_stall,
    input  hsv_pix_t hsv,
    input  logic     rgb_valid,
    input  logic     rgb_stall,
    input  rgb_pix_t rgb,
    output int       fail_count,
    output int       pending_beats
);

    rgb_pix_t rgb_expected[$];
    int       errors;
    int       beat_no;

    initial
    begin
        errors        = 0;
        beat_no       = 0;
        fail_count    = 0;
        pending_beats = 0;
    end

    // six-sector HSV to RGB, exact integer form, truncating like the C cast
    function automatic rgb_pix_t convert_pixel(input hsv_pix_t px);
        longint unsigned maxc;
        longint unsigned hue_one;
        longint unsigned den;
        longint unsigned x;
        longint unsigned frac;
        longint unsigned s;
        longint unsigned v;
        longint unsigned pv;
        longint unsigned qv;
        longint unsigned tv;
        logic [SECTOR_BITS-1:0] sector;
        rgb_pix_t out;
        maxc    = (64'd1 << CHANNEL_BITS) - 1;
        hue_one = 64'd1 << HUE_BITS;
        den     = maxc * hue_one;
        s       = 64'(px.saturation);
        v       = 64'(px.brightness);
        x       = 64'(px.hue) * 6;
        sector  = SECTOR_BITS'(x >> HUE_BITS);
        frac    = x & (hue_one - 1);
        pv      = (v * (maxc - s)) / maxc;
        qv      = (v * (den - frac * s)) / den;
        tv      = (v * (den - (hue_one - frac) * s)) / den;
        case (sector)
            SEC_RED_YEL:
            begin
                out.red   = CHANNEL_BITS'(v);
                out.green = CHANNEL_BITS'(tv);
                out.blue  = CHANNEL_BITS'(pv);
            end
            SEC_YEL_GRN:
            begin
                out.red   = CHANNEL_BITS'(qv);
                out.green = CHANNEL_BITS'(v);
                out.blue  = CHANNEL_BITS'(pv);
            end
            SEC_GRN_CYN:
            begin
                out.red   = CHANNEL_BITS'(pv);
                out.green = CHANNEL_BITS'(v);
                out.blue  = CHANNEL_BITS'(tv);
            end
            SEC_CYN_BLU:
            begin
                out.red   = CHANNEL_BITS'(pv);
                out.green = CHANNEL_BITS'(qv);
                out.blue  = CHANNEL_BITS'(v);
            end
            SEC_BLU_MAG:
            begin
                out.red   = CHANNEL_BITS'(tv);
                out.green = CHANNEL_BITS'(pv);
                out.blue  = CHANNEL_BITS'(v);
            end
            default: // magenta to red
            begin
                out.red   = CHANNEL_BITS'(v);
                out.green = CHANNEL_BITS'(pv);
                out.blue  = CHANNEL_BITS'(qv);
            end
        endcase
        return out;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] rgb beat %0d: %s got %0d, want %0d", $time, beat_no, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        rgb_pix_t want;
        if (rst_n)
        begin
            if (rgb_valid && !rgb_stall)
            begin
                if (rgb_expected.size() == 0)
                    report_mismatch("unexpected beat", int'(rgb), 0);
                else
                begin
                    want = rgb_expected.pop_front();
                    if (rgb.red !== want.red)
                        report_mismatch("red", int'(rgb.red), int'(want.red));
                    if (rgb.green !== want.green)
                        report_mismatch("green", int'(rgb.green), int'(want.green));
                    if (rgb.blue !== want.blue)
                        report_mismatch("blue", int'(rgb.blue), int'(want.blue));
                end
                beat_no++;
            end
            if (hsv_valid && !hsv_stall)
                rgb_expected.insert(rgb_expected.size(), convert_pixel(hsv));
        end
        fail_count    <= errors;
        pending_beats <= rgb_expected.size();
    end

endmodule

### dv/tb_hsv_to_rgb_converter.sv
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter;
    import hsv2rgb_pkg::*;

    localparam int NUM_RANDOM  = 950;
    localparam int STUCK_LIMIT = 2000;

    logic     clk;
    logic     rst_n;
    logic     hsv_valid;
    logic     hsv_stall;
    hsv_pix_t hsv;
    logic     rgb_valid;
    logic     rgb_stall;
    rgb_pix_t rgb;

    int fail_count;
    int pending_beats;
    int stuck_cycles;
    bit hsv_busy_run;   // stretch with no input gaps
    bit rgb_busy_run;   // stretch with no output stalls

    hsv_to_rgb_converter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_stall (hsv_stall),
        .hsv       (hsv),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb       (rgb)
    );

    hsv_to_rgb_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .hsv_valid     (hsv_valid),
        .hsv_stall     (hsv_stall),
        .hsv           (hsv),
        .rgb_valid     (rgb_valid),
        .rgb_stall     (rgb_stall),
        .rgb           (rgb),
        .fail_count    (fail_count),
        .pending_beats (pending_beats)
    );

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        hsv_valid = 1'b0;
        hsv       = '0;
        rgb_stall = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait(input bit busy_run);
        return busy_run ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic send_pixel(input hsv_pix_t px);
        int gap;
        gap = draw_wait(hsv_busy_run);
        if (gap > 0)
        begin
            hsv_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hsv_valid <= 1'b1;
        hsv       <= px;
        @(posedge clk);
        while (hsv_stall)
            @(posedge clk);
    endtask

    task automatic send_hsv(input int h, input int s, input int v);
        hsv_pix_t px;
        px.hue        = HUE_BITS'(h);
        px.saturation = CHANNEL_BITS'(s);
        px.brightness = CHANNEL_BITS'(v);
        send_pixel(px);
    endtask

    // partly uniform; the rest pinned to channel extremes or sector edges
    function automatic hsv_pix_t random_pixel();
        hsv_pix_t px;
        int k;
        px.hue        = HUE_BITS'($urandom);
        px.saturation = CHANNEL_BITS'($urandom);
        px.brightness = CHANNEL_BITS'($urandom);
        if ($urandom_range(0, 3) == 0)
        begin
            k = $urandom_range(0, 6);
            px.hue = HUE_BITS'((k * 65536 + 5) / 6 + $urandom_range(0, 2) - 1);
        end
        case ($urandom_range(0, 7))
            0: px.saturation = '0;
            1: px.saturation = CH_MAX;
            2: px.brightness = '0;
            3: px.brightness = CH_MAX;
            default: ;
        endcase
        return px;
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        hsv_busy_run = 1'b0;

        // sector edges at full saturation and value
        send_hsv(0, 255, 255);
        send_hsv(10922, 255, 255);
        send_hsv(10923, 255, 255);
        send_hsv(21845, 255, 255);
        send_hsv(21846, 255, 255);
        send_hsv(32767, 255, 255);
        send_hsv(32768, 255, 255);
        send_hsv(43690, 255, 255);
        send_hsv(43691, 255, 255);
        send_hsv(54613, 255, 255);
        send_hsv(54614, 255, 255);
        send_hsv(65535, 255, 255);
        // grey: no saturation
        send_hsv(16'h5555, 0, 8'hAA);
        send_hsv(16'hFFFF, 0, 255);
        send_hsv(0, 0, 0);
        // black, near-black and mixed saturation and value
        send_hsv(16'h1234, 255, 0);
        send_hsv(16'hFFFF, 1, 1);
        send_hsv(16'h2AAA, 254, 255);
        send_hsv(16'hAAAA, 8'h80, 8'h7F);
        send_hsv(16'hC000, 8'h55, 8'hAA);
        send_hsv(16'h9999, 255, 128);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % 64 == 0)
                hsv_busy_run = ($urandom_range(0, 3) == 0);
            send_pixel(random_pixel());
        end
        hsv_valid <= 1'b0;

        // pending count is registered, so it lags the last accepted beat
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // receiver back-pressure: a random hold before each output beat
    initial
    begin
        int hold;
        int beats;
        beats = 0;
        rgb_busy_run = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (beats % 50 == 0)
                rgb_busy_run = ($urandom_range(0, 3) == 0);
            hold = draw_wait(rgb_busy_run);
            if (hold > 0)
            begin
                rgb_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                rgb_stall <= 1'b0;
            end
            @(posedge clk);
            while (!(rgb_valid && !rgb_stall))
                @(posedge clk);
            beats++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            stuck_cycles <= 0;
        else if ((hsv_valid && !hsv_stall) || (rgb_valid && !rgb_stall))
            stuck_cycles <= 0;
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule
